[rtl/hduart_pkg.sv]
// ----------------------------------------------------------------------------
// hduart_pkg
// Shared types and constants of the half-duplex 8N1 UART.
// ----------------------------------------------------------------------------
package hduart_pkg;

  localparam int unsigned TickW    = 16;
  localparam int unsigned HalfW    = 15;
  localparam int unsigned DataW    = 8;
  localparam int unsigned FrameW   = 10;
  localparam int unsigned BitsW    = 4;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [TickW-1:0] BitTicksRst     = TickW'(104);
  localparam logic [HalfW-1:0] HalfBitTicksRst = HalfW'(52);

  // receive takes start, 8 data and stop samples; transmit shifts 9 after start
  localparam logic [BitsW-1:0] RxBits = BitsW'(10);
  localparam logic [BitsW-1:0] TxBits = BitsW'(9);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIT_TICKS      = 2'd0,
    CFG_HALF_BIT_TICKS = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TX   = 2'd1,
    MODE_RX   = 2'd2
  } mode_e;

  typedef struct packed {
    logic             tx_line;
    logic             tx_busy;
    logic             rx_busy;
    logic             rx_valid;
    logic [DataW-1:0] rx_data;
    logic             rx_error;
  } result_t;

endpackage

[rtl/hduart_core.sv]
// ----------------------------------------------------------------------------
// hduart_core
// Line state of the UART: timing registers, bit counter, shift frame and
// pending transmit request, advanced by one tick per step request.
// ----------------------------------------------------------------------------
module hduart_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hduart_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [hduart_pkg::TickW-1:0]      cfg_data_i,
  input  logic                              step_i,
  input  logic                              rx_line_i,
  input  logic                              tx_start_i,
  input  logic [hduart_pkg::DataW-1:0]      tx_data_i,
  output hduart_pkg::result_t               res_o
);
  import hduart_pkg::*;

  logic [TickW-1:0]  bit_ticks_q;
  logic [HalfW-1:0]  half_ticks_q;

  mode_e             mode_q, mode_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [BitsW-1:0]  bits_q, bits_d;
  logic [FrameW-1:0] shift_q, shift_d;
  logic              line_q, line_d;
  logic              rx_prev_q, rx_prev_d;
  logic              pend_vld_q, pend_vld_d;
  logic [DataW-1:0]  pend_byte_q, pend_byte_d;
  logic [DataW-1:0]  rx_hold_q, rx_hold_d;
  logic              valid_d, error_d;

  logic              edge_det;
  logic              expired;
  logic [TickW-1:0]  tick_dec;
  logic [FrameW-1:0] rx_shift;
  logic [BitsW-1:0]  bits_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q  <= BitTicksRst;
      half_ticks_q <= HalfBitTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BIT_TICKS:      bit_ticks_q  <= cfg_data_i;
        CFG_HALF_BIT_TICKS: half_ticks_q <= cfg_data_i[HalfW-1:0];
        default: ;
      endcase
    end
  end

  assign edge_det = rx_prev_q & ~rx_line_i;
  assign expired  = (tick_q <= TickW'(1));
  assign tick_dec = tick_q - TickW'(1);
  assign rx_shift = {rx_line_i, shift_q[FrameW-1:1]};
  assign bits_dec = bits_q - BitsW'(1);

  // next state
  always_comb begin
    mode_d      = mode_q;
    tick_d      = tick_q;
    bits_d      = bits_q;
    shift_d     = shift_q;
    line_d      = line_q;
    rx_prev_d   = rx_line_i;
    pend_vld_d  = pend_vld_q;
    pend_byte_d = pend_byte_q;
    rx_hold_d   = rx_hold_q;
    valid_d     = 1'b0;
    error_d     = 1'b0;

    // a new request is latched only when none is waiting
    if (tx_start_i && !pend_vld_q) begin
      pend_vld_d  = 1'b1;
      pend_byte_d = tx_data_i;
    end

    if (mode_q == MODE_RX) begin
      if (expired) begin
        shift_d = rx_shift;
        bits_d  = bits_dec;
        tick_d  = bit_ticks_q;
        if (bits_dec == '0) begin
          mode_d = MODE_IDLE;
          if (rx_shift[FrameW-1] && !rx_shift[0]) begin
            rx_hold_d = rx_shift[DataW:1];
            valid_d   = 1'b1;
          end else begin
            error_d = 1'b1;
          end
        end
      end else begin
        tick_d = tick_dec;
      end
    end else if (edge_det) begin
      // start edge wins over a transmit frame in flight, line goes back to mark
      line_d  = 1'b1;
      mode_d  = MODE_RX;
      tick_d  = TickW'(half_ticks_q);
      bits_d  = RxBits;
      shift_d = '0;
    end else if (mode_q == MODE_TX) begin
      if (expired) begin
        tick_d = bit_ticks_q;
        if (bits_q == '0) begin
          mode_d = MODE_IDLE;
          line_d = 1'b1;
        end else begin
          line_d  = shift_q[0];
          shift_d = {1'b0, shift_q[FrameW-1:1]};
          bits_d  = bits_dec;
        end
      end else begin
        tick_d = tick_dec;
      end
    end

    // a waiting byte starts on the same tick the line becomes free
    if (mode_d == MODE_IDLE && pend_vld_d) begin
      mode_d     = MODE_TX;
      line_d     = 1'b0;
      shift_d    = {1'b0, 1'b1, pend_byte_d};
      bits_d     = TxBits;
      tick_d     = bit_ticks_q;
      pend_vld_d = 1'b0;
    end
  end

  // result of this tick
  always_comb begin
    res_o.tx_line  = line_d;
    res_o.tx_busy  = (mode_d == MODE_TX) || pend_vld_d;
    res_o.rx_busy  = (mode_d == MODE_RX);
    res_o.rx_valid = valid_d;
    res_o.rx_data  = rx_hold_d;
    res_o.rx_error = error_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      tick_q     <= '0;
      bits_q     <= '0;
      shift_q    <= '0;
      line_q     <= 1'b1;
      rx_prev_q  <= 1'b1;
      pend_vld_q <= 1'b0;
      rx_hold_q  <= '0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      tick_q     <= tick_d;
      bits_q     <= bits_d;
      shift_q    <= shift_d;
      line_q     <= line_d;
      rx_prev_q  <= rx_prev_d;
      pend_vld_q <= pend_vld_d;
      rx_hold_q  <= rx_hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      pend_byte_q <= pend_byte_d;
    end
  end

  a_valid_error_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.rx_valid && res_o.rx_error))
    else $error("rx_valid and rx_error together");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> !pend_vld_q)
    else $error("request left waiting on an idle line");

  a_rx_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_RX) |-> (bits_q != '0 && bits_q <= RxBits))
    else $error("receive bit count out of range");

  a_tx_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_TX) |-> (bits_q <= TxBits))
    else $error("transmit bit count out of range");

endmodule

[rtl/half_duplex_uart_8n1.sv]
// ----------------------------------------------------------------------------
// half_duplex_uart_8n1
// Half-duplex 8N1 UART stepped one tick per input request, with a
// two-entry result buffer on the output side.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_ready_o    rx_line_i, tx_start_i, tx_data_i
//   out      source     out_valid_o / out_ready_i  tx_line_o .. rx_error_o
//   cfg      sink       cfg_we_i                   cfg_idx_i, cfg_data_i
//
// one request a cycle while in_ready_o is high; the tick is computed between the
// state registers and the output entry, or the skid entry while a result waits.
// reset gives 104 ticks per bit, 52 to the first sample, line at mark.
// the skid entry lets one more request in while a result waits; input stalls
// only once both result entries are full.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hduart_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hduart_pkg::TickW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           rx_line_i,
  input  logic                           tx_start_i,
  input  logic [hduart_pkg::DataW-1:0]   tx_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           tx_line_o,
  output logic                           tx_busy_o,
  output logic                           rx_busy_o,
  output logic                           rx_valid_o,
  output logic [hduart_pkg::DataW-1:0]   rx_data_o,
  output logic                           rx_error_o
);
  import hduart_pkg::*;

  logic    in_fire, out_fire;
  result_t res;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_vld_q, out_vld_d;
  logic    skid_vld_q, skid_vld_d;

  assign in_ready_o = !skid_vld_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_vld_q && out_ready_i;

  hduart_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_fire),
    .rx_line_i  (rx_line_i),
    .tx_start_i (tx_start_i),
    .tx_data_i  (tx_data_i),
    .res_o      (res)
  );

  always_comb begin
    out_d      = out_q;
    skid_d     = skid_q;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || out_fire) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = res;
        out_vld_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_vld_q;
  assign tx_line_o   = out_q.tx_line;
  assign tx_busy_o   = out_q.tx_busy;
  assign rx_busy_o   = out_q.rx_busy;
  assign rx_valid_o  = out_q.rx_valid;
  assign rx_data_o   = out_q.rx_data;
  assign rx_error_o  = out_q.rx_error;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held with empty output register");

endmodule
